// File: src/adam_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_pkg
// Shared types and constants for the fixed-point Adam update pipeline.
// ---------------------------------------------------------------------------
package adam_pkg;

  localparam logic [24:0] ONE_Q24     = 25'd16777216;
  localparam logic [40:0] STEP_CAP    = 41'd1099511627776;

  // Pipeline depths of the iterative sections, one result bit per stage.
  localparam int DIV_STAGES  = 56;
  localparam int ROOT_STAGES = 40;
  localparam int QUOT_STAGES = 41;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_LEARN_RATE   = 3'd0;
  localparam logic [2:0] REG_FIRST_DECAY  = 3'd1;
  localparam logic [2:0] REG_SECOND_DECAY = 3'd2;
  localparam logic [2:0] REG_STABILITY    = 3'd3;
  localparam logic [2:0] REG_FIRST_POWER  = 3'd4;
  localparam logic [2:0] REG_SECOND_POWER = 3'd5;

  localparam logic [23:0] RST_LEARN_RATE   = 24'd16777;
  localparam logic [23:0] RST_FIRST_DECAY  = 24'd15099494;
  localparam logic [23:0] RST_SECOND_DECAY = 24'd16760439;
  localparam logic [23:0] RST_STABILITY    = 24'd1;
  localparam logic [23:0] RST_FIRST_POWER  = 24'd15099494;
  localparam logic [23:0] RST_SECOND_POWER = 24'd16760439;

  typedef struct packed {
    logic [23:0] learn_rate;
    logic [23:0] first_decay;
    logic [23:0] second_decay;
    logic [23:0] stability;
    logic [23:0] first_power;
    logic [23:0] second_power;
  } adam_coef_t;

  // Values that ride along the pipeline with each element
  typedef struct packed {
    logic signed [31:0] param;
    logic signed [31:0] mean;
    logic        [31:0] square;
  } adam_side_t;

endpackage
`default_nettype wire

// File: src/adam_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_if
// Valid/ready channels for element requests, results and register writes.
// ---------------------------------------------------------------------------
interface adam_elem_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gradient;
  logic signed [31:0] param_value;
  logic signed [31:0] mean_estimate;
  logic        [31:0] square_estimate;
  modport source(output valid, gradient, param_value, mean_estimate, square_estimate,
                 input ready);
  modport sink(input valid, gradient, param_value, mean_estimate, square_estimate,
               output ready);
endinterface

interface adam_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_param_value;
  logic signed [31:0] new_mean_estimate;
  logic        [31:0] new_square_estimate;
  modport source(output valid, new_param_value, new_mean_estimate, new_square_estimate,
                 input ready);
  modport sink(input valid, new_param_value, new_mean_estimate, new_square_estimate,
               output ready);
endinterface

interface adam_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/adam_optimizer_update.sv
`default_nettype none
// Pipeline: 4 moment, 56 divide, 40 root and 44 step stages from element request
//   to result, including the output register.
// Throughput: one element per cycle; a waiting result freezes every stage,
//   and the request side stalls with it.
// Reset: synchronous; clears all stage valid bits and loads register defaults.
// ---------------------------------------------------------------------------
// adam_optimizer_update
// Fixed-point Adam step per element: moment blend, bias correction, root,
// scaled quotient and saturated parameter update.
// ---------------------------------------------------------------------------
module adam_optimizer_update (
  input  wire logic   clk,
  input  wire logic   rst,
  adam_elem_if.sink   elem,
  adam_res_if.source  result,
  adam_cfg_if.sink    cfg
);
  import adam_pkg::*;

  adam_coef_t  coef;
  logic        adv;

  logic        mo_valid;
  adam_side_t  mo_side;
  logic        bd_valid;
  logic [55:0] bd_mean_hat;
  logic [55:0] bd_square_hat;
  adam_side_t  bd_side;
  logic        sq_valid;
  logic [39:0] sq_root;
  logic [55:0] sq_mean_hat;
  adam_side_t  sq_side;
  logic        res_valid;
  adam_side_t  res;

  assign adv        = !res_valid || result.ready;
  assign elem.ready = adv;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.learn_rate   <= RST_LEARN_RATE;
      coef.first_decay  <= RST_FIRST_DECAY;
      coef.second_decay <= RST_SECOND_DECAY;
      coef.stability    <= RST_STABILITY;
      coef.first_power  <= RST_FIRST_POWER;
      coef.second_power <= RST_SECOND_POWER;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LEARN_RATE:   coef.learn_rate   <= cfg.data;
        REG_FIRST_DECAY:  coef.first_decay  <= cfg.data;
        REG_SECOND_DECAY: coef.second_decay <= cfg.data;
        REG_STABILITY:    coef.stability    <= cfg.data;
        REG_FIRST_POWER:  coef.first_power  <= cfg.data;
        REG_SECOND_POWER: coef.second_power <= cfg.data;
        default: ;
      endcase
    end
  end

  adam_moment u_moment (
    .clk             (clk),
    .rst             (rst),
    .en              (adv),
    .coef            (coef),
    .in_valid        (elem.valid),
    .gradient        (elem.gradient),
    .param_value     (elem.param_value),
    .mean_estimate   (elem.mean_estimate),
    .square_estimate (elem.square_estimate),
    .out_valid       (mo_valid),
    .out_side        (mo_side)
  );

  adam_bias_div u_bias_div (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .coef       (coef),
    .in_valid   (mo_valid),
    .in_side    (mo_side),
    .out_valid  (bd_valid),
    .mean_hat   (bd_mean_hat),
    .square_hat (bd_square_hat),
    .out_side   (bd_side)
  );

  adam_sqrt u_sqrt (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (bd_valid),
    .mean_hat     (bd_mean_hat),
    .square_hat   (bd_square_hat),
    .in_side      (bd_side),
    .out_valid    (sq_valid),
    .root         (sq_root),
    .out_mean_hat (sq_mean_hat),
    .out_side     (sq_side)
  );

  adam_step u_step (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .coef      (coef),
    .in_valid  (sq_valid),
    .root      (sq_root),
    .mean_hat  (sq_mean_hat),
    .in_side   (sq_side),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign result.valid               = res_valid;
  assign result.new_param_value     = res.param;
  assign result.new_mean_estimate   = res.mean;
  assign result.new_square_estimate = res.square;

endmodule
`default_nettype wire

// File: src/adam_moment.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_moment
// Four-stage moment blend: new first and second moments, rounded, saturated.
// ---------------------------------------------------------------------------
module adam_moment (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire adam_pkg::adam_coef_t coef,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] gradient,
  input  wire logic signed [31:0] param_value,
  input  wire logic signed [31:0] mean_estimate,
  input  wire logic        [31:0] square_estimate,
  output logic                    out_valid,
  output adam_pkg::adam_side_t    out_side
);
  import adam_pkg::*;

  logic v1, v2, v3;

  logic signed [24:0] b1_s;
  logic        [24:0] c1;
  logic signed [25:0] c1_s;
  logic        [24:0] c2;

  logic signed [56:0] s1_pm;
  logic signed [57:0] s1_pg;
  logic signed [63:0] s1_gg;
  logic        [55:0] s1_pv;
  logic signed [31:0] s1_param;

  logic signed [31:0] s2_mean;
  logic        [39:0] s2_g2;
  logic        [55:0] s2_pv;
  logic signed [31:0] s2_param;

  logic        [48:0] s3_pl;
  logic        [40:0] s3_ph;
  logic        [55:0] s3_pv;
  logic signed [31:0] s3_mean;
  logic signed [31:0] s3_param;

  logic signed [58:0] msum;
  logic signed [58:0] mrnd;
  logic signed [34:0] mq;
  logic signed [31:0] mean_sat;
  logic        [63:0] ggr;
  logic        [65:0] vsum;
  logic        [65:0] vrnd;
  logic        [41:0] vq;
  logic        [31:0] square_sat;

  assign b1_s = $signed({1'b0, coef.first_decay});
  assign c1   = ONE_Q24 - {1'b0, coef.first_decay};
  assign c1_s = $signed({1'b0, c1});
  assign c2   = ONE_Q24 - {1'b0, coef.second_decay};

  always_comb begin
    msum = 59'(s1_pm) + 59'(s1_pg);
    mrnd = msum + 59'sd8388608;
    mq   = mrnd[58:24];
    if (mq > 35'sd2147483647) begin
      mean_sat = 32'sh7fffffff;
    end else if (mq < -35'sd2147483648) begin
      mean_sat = 32'sh80000000;
    end else begin
      mean_sat = mq[31:0];
    end
    ggr = $unsigned(s1_gg) + 64'd8388608;
  end

  always_comb begin
    vsum = 66'(s3_pv) + 66'(s3_pl) + 66'({s3_ph, 24'b0});
    vrnd = vsum + 66'd8388608;
    vq   = vrnd[65:24];
    square_sat = (vq[41:32] != '0) ? 32'hffffffff : vq[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pm    <= b1_s * mean_estimate;
      s1_pg    <= c1_s * gradient;
      s1_gg    <= gradient * gradient;
      s1_pv    <= coef.second_decay * square_estimate;
      s1_param <= param_value;

      s2_mean  <= mean_sat;
      s2_g2    <= ggr[63:24];
      s2_pv    <= s1_pv;
      s2_param <= s1_param;

      s3_pl    <= c2 * s2_g2[23:0];
      s3_ph    <= c2 * s2_g2[39:24];
      s3_pv    <= s2_pv;
      s3_mean  <= s2_mean;
      s3_param <= s2_param;

      out_side.param  <= s3_param;
      out_side.mean   <= s3_mean;
      out_side.square <= square_sat;
    end
  end

endmodule
`default_nettype wire

// File: src/adam_bias_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_bias_div
// Bias correction: two restoring dividers side by side, one quotient bit
// per stage, dividing both moments by one minus their decay powers.
// ---------------------------------------------------------------------------
module adam_bias_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire adam_pkg::adam_coef_t coef,
  input  wire logic                 in_valid,
  input  wire adam_pkg::adam_side_t in_side,
  output logic                      out_valid,
  output logic [55:0]               mean_hat,
  output logic [55:0]               square_hat,
  output adam_pkg::adam_side_t      out_side
);
  import adam_pkg::*;

  typedef struct packed {
    logic [24:0] rem;
    logic [55:0] qd;
  } div_lane_t;

  typedef struct packed {
    div_lane_t  mean_lane;
    div_lane_t  square_lane;
    adam_side_t side;
  } div_st_t;

  function automatic div_lane_t div_step(div_lane_t a, logic [24:0] d);
    logic [25:0] t;
    div_lane_t   r;
    t = {a.rem, a.qd[55]};
    if (t >= {1'b0, d}) begin
      r.rem = 25'(t - {1'b0, d});
      r.qd  = {a.qd[54:0], 1'b1};
    end else begin
      r.rem = t[24:0];
      r.qd  = {a.qd[54:0], 1'b0};
    end
    return r;
  endfunction

  logic [24:0] d_mean;
  logic [24:0] d_square;
  logic [31:0] mean_mag;
  div_st_t     st_in;
  div_st_t     st  [1:DIV_STAGES];
  logic        vld [1:DIV_STAGES];

  assign d_mean   = ONE_Q24 - {1'b0, coef.first_power};
  assign d_square = ONE_Q24 - {1'b0, coef.second_power};
  assign mean_mag = in_side.mean[31] ? 32'(-in_side.mean) : 32'(in_side.mean);

  always_comb begin
    st_in.mean_lane.rem   = '0;
    st_in.mean_lane.qd    = {mean_mag, 24'b0};
    st_in.square_lane.rem = '0;
    st_in.square_lane.qd  = {in_side.square, 24'b0};
    st_in.side            = in_side;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[1].mean_lane   <= div_step(st_in.mean_lane, d_mean);
      st[1].square_lane <= div_step(st_in.square_lane, d_square);
      st[1].side        <= st_in.side;
      for (int k = 2; k <= DIV_STAGES; k++) begin
        st[k].mean_lane   <= div_step(st[k-1].mean_lane, d_mean);
        st[k].square_lane <= div_step(st[k-1].square_lane, d_square);
        st[k].side        <= st[k-1].side;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= DIV_STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= DIV_STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  assign out_valid  = vld[DIV_STAGES];
  assign mean_hat   = st[DIV_STAGES].mean_lane.qd;
  assign square_hat = st[DIV_STAGES].square_lane.qd;
  assign out_side   = st[DIV_STAGES].side;

endmodule
`default_nettype wire

// File: src/adam_sqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_sqrt
// Digit-by-digit integer square root of the corrected second moment in
// Q32.24, one root bit per stage.
// ---------------------------------------------------------------------------
module adam_sqrt (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [55:0]          mean_hat,
  input  wire logic [55:0]          square_hat,
  input  wire adam_pkg::adam_side_t in_side,
  output logic                      out_valid,
  output logic [39:0]               root,
  output logic [55:0]               out_mean_hat,
  output adam_pkg::adam_side_t      out_side
);
  import adam_pkg::*;

  typedef struct packed {
    logic [41:0] rem;
    logic [39:0] root;
    logic [79:0] rad;
  } root_lane_t;

  typedef struct packed {
    root_lane_t lane;
    logic [55:0] mean_hat;
    adam_side_t  side;
  } root_st_t;

  function automatic root_lane_t root_step(root_lane_t a);
    logic [43:0] t;
    logic [43:0] trial;
    root_lane_t  r;
    t     = {a.rem, a.rad[79:78]};
    trial = {2'b00, a.root, 2'b01};
    r.rad = {a.rad[77:0], 2'b00};
    if (t >= trial) begin
      r.rem  = 42'(t - trial);
      r.root = {a.root[38:0], 1'b1};
    end else begin
      r.rem  = t[41:0];
      r.root = {a.root[38:0], 1'b0};
    end
    return r;
  endfunction

  root_st_t st_in;
  root_st_t st  [1:ROOT_STAGES];
  logic     vld [1:ROOT_STAGES];

  always_comb begin
    st_in.lane.rem  = '0;
    st_in.lane.root = '0;
    st_in.lane.rad  = {square_hat, 24'b0};
    st_in.mean_hat  = mean_hat;
    st_in.side      = in_side;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[1].lane     <= root_step(st_in.lane);
      st[1].mean_hat <= st_in.mean_hat;
      st[1].side     <= st_in.side;
      for (int k = 2; k <= ROOT_STAGES; k++) begin
        st[k].lane     <= root_step(st[k-1].lane);
        st[k].mean_hat <= st[k-1].mean_hat;
        st[k].side     <= st[k-1].side;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= ROOT_STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= ROOT_STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  assign out_valid    = vld[ROOT_STAGES];
  assign root         = st[ROOT_STAGES].lane.root;
  assign out_mean_hat = st[ROOT_STAGES].mean_hat;
  assign out_side     = st[ROOT_STAGES].side;

endmodule
`default_nettype wire

// File: src/adam_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_step
// Step size lr * mh / (root + eps), capped, then applied to the value.
// Split multiply, overflow precheck, bit-per-stage quotient, output register.
// ---------------------------------------------------------------------------
module adam_step (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire adam_pkg::adam_coef_t coef,
  input  wire logic                 in_valid,
  input  wire logic [39:0]          root,
  input  wire logic [55:0]          mean_hat,
  input  wire adam_pkg::adam_side_t in_side,
  output logic                      out_valid,
  output adam_pkg::adam_side_t      out_res
);
  import adam_pkg::*;

  typedef struct packed {
    logic [40:0] rem;
    logic [40:0] qd;
    logic [40:0] denom;
    logic        ovf;
    adam_side_t  side;
  } quot_st_t;

  function automatic quot_st_t quot_step(quot_st_t a);
    logic [41:0] t;
    quot_st_t    r;
    r = a;
    t = {a.rem, a.qd[40]};
    if (t >= {1'b0, a.denom}) begin
      r.rem = 41'(t - {1'b0, a.denom});
      r.qd  = {a.qd[39:0], 1'b1};
    end else begin
      r.rem = t[40:0];
      r.qd  = {a.qd[39:0], 1'b0};
    end
    return r;
  endfunction

  logic [23:0] eps_eff;

  logic        va, vb;
  logic [55:0] a_lo;
  logic [47:0] a_hi;
  logic [40:0] a_denom;
  adam_side_t  a_side;
  logic [79:0] b_prod;
  logic [40:0] b_denom;
  adam_side_t  b_side;

  quot_st_t    st_in;
  quot_st_t    st  [1:QUOT_STAGES];
  logic        vld [1:QUOT_STAGES];

  logic [40:0]        step_val;
  logic signed [42:0] pnew;
  logic signed [31:0] pnew_sat;

  // a zero epsilon counts as one lsb so the divisor is never zero
  assign eps_eff = (coef.stability == '0) ? 24'd1 : coef.stability;

  always_comb begin
    st_in.ovf   = {2'b00, b_prod[79:41]} >= b_denom;
    st_in.rem   = st_in.ovf ? '0 : {2'b00, b_prod[79:41]};
    st_in.qd    = b_prod[40:0];
    st_in.denom = b_denom;
    st_in.side  = b_side;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lo    <= mean_hat[31:0] * coef.learn_rate;
      a_hi    <= mean_hat[55:32] * coef.learn_rate;
      a_denom <= 41'(root) + 41'(eps_eff);
      a_side  <= in_side;

      b_prod  <= 80'(a_lo) + 80'({a_hi, 32'b0});
      b_denom <= a_denom;
      b_side  <= a_side;

      st[1] <= quot_step(st_in);
      for (int k = 2; k <= QUOT_STAGES; k++) st[k] <= quot_step(st[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      for (int k = 1; k <= QUOT_STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vld[1] <= vb;
      for (int k = 2; k <= QUOT_STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  always_comb begin
    if (st[QUOT_STAGES].ovf || st[QUOT_STAGES].qd > STEP_CAP) begin
      step_val = STEP_CAP;
    end else begin
      step_val = st[QUOT_STAGES].qd;
    end
    if (st[QUOT_STAGES].side.mean[31]) begin
      pnew = 43'(st[QUOT_STAGES].side.param) + $signed({2'b00, step_val});
    end else begin
      pnew = 43'(st[QUOT_STAGES].side.param) - $signed({2'b00, step_val});
    end
    if (pnew > 43'sd2147483647) begin
      pnew_sat = 32'sh7fffffff;
    end else if (pnew < -43'sd2147483648) begin
      pnew_sat = 32'sh80000000;
    end else begin
      pnew_sat = pnew[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QUOT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.param  <= pnew_sat;
      out_res.mean   <= st[QUOT_STAGES].side.mean;
      out_res.square <= st[QUOT_STAGES].side.square;
    end
  end

`ifndef ASSERT_OFF
  a_out_follows: assert property (@(posedge clk)
    !rst && en |=> out_valid == $past(vld[QUOT_STAGES]))
    else $error("output valid did not follow last quotient stage");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_res) && $stable(out_valid))
    else $error("output changed while pipeline stalled");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    vld[QUOT_STAGES] |-> step_val <= STEP_CAP)
    else $error("step magnitude above cap");
`endif

endmodule
`default_nettype wire
